### rtl/assert_macros.svh
// Assertion macros used by the RTL of the height lookup block.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HHL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define HHL_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define HHL_ASSERT(lbl, clk, rst_n, prop)
`define HHL_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/hhl_pkg.sv
// Package of the height lookup block: grid sizes, formats, transaction types.
// No dependencies.
package hhl_pkg;
	localparam int GRID_W = 64;
	localparam int GRID_H = 256;
	localparam int COL_W = $clog2(GRID_W);
	localparam int ROW_W = $clog2(GRID_H);
	localparam int NCOL_W = $clog2(GRID_W + 1);
	localparam int NROW_W = $clog2(GRID_H + 1);
	localparam int FRAC_BITS = 24;
	localparam int ELEV_W = 32;
	localparam int BANK_DEPTH = (GRID_W / 2) * (GRID_H / 2);
	localparam int BANK_AW = $clog2(BANK_DEPTH);
	localparam int CFG_W = 32;

	typedef enum logic [1:0] {
		CFG_X_SCALE   = 2'd0,
		CFG_Z_SCALE   = 2'd1,
		CFG_GRID_COLS = 2'd2,
		CFG_GRID_ROWS = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         col;
		logic [7:0]         row;
		logic signed [31:0] elevation;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic               off_grid;
	} out_item_t;
endpackage

### rtl/hhl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hhl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/heightfield_height_lookup_top.sv
// Top level of the height lookup block: eight-stage pipeline, four RAM banks.
// Depends on hhl_pkg, hhl_ram and assert_macros.svh.
//
// Usage: the input channel carries two kinds of transaction. A write (cmd 0)
// stores one elevation at (col, row) and gives no result. A query (cmd 1)
// gives one result: the interpolated height at (pos_x, pos_z) and off_grid.
// The grid is held in four RAM banks split by column and row parity, so the
// four corners of a cell are read in the same cycle and one transaction
// enters per cycle; throughput is one transaction per cycle, limited only
// by the output handshake. Each stage holds its item while the stage after
// it is full and blocked; empty stages still fill, so the block keeps
// taking transactions until every stage is occupied. Configuration writes
// go to plain registers; the user must make them while the pipeline is
// empty, and the block itself does not enforce this.
// Reset clears all valid bits and loads the scales with 1.0 and the grid size
// with 64 columns by 256 rows. Elevation memory is not cleared: every entry
// a query touches must be written first.
`include "assert_macros.svh"
module heightfield_height_lookup_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hhl_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hhl_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import hhl_pkg::*;

	localparam int XQ_W = 48;
	localparam int FI_W = XQ_W - FRAC_BITS;
	localparam int SUM_W = 60;

	logic [31:0] x_scale_q, z_scale_q;
	logic [6:0]  grid_cols_q;
	logic [8:0]  grid_rows_q;
	logic [NCOL_W-1:0] nc;
	logic [NROW_W-1:0] nr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	// stage 1
	logic               cmd_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic signed [31:0] elev_s1;
	logic signed [63:0] xprod_s1, zprod_s1;
	logic signed [65:0] zprod_full;
	logic signed [32:0] negz;
	// stage 2
	logic               cmd_s2, off_s2;
	logic [COL_W-1:0]   col_s2, x0_s2;
	logic [ROW_W-1:0]   row_s2, z0_s2;
	logic signed [31:0] elev_s2;
	logic signed [XQ_W-1:0] xq_s2, zq_s2;
	logic signed [XQ_W-1:0] xq_c, zq_c;
	logic [COL_W-1:0]   x0_c;
	logic [ROW_W-1:0]   z0_c;
	logic               off_c;
	// stage 3
	logic               off_s3, xp_s3, zp_s3;
	logic signed [XQ_W-1:0] fx_s3, fz_s3;
	logic [ELEV_W-1:0]  rdata [4];
	// stage 4
	logic               off_s4, odd_s4, low_s4;
	logic signed [XQ_W-1:0] fx_s4, fz_s4;
	logic signed [ELEV_W-1:0] h00_s4, h10_s4, h01_s4, h11_s4;
	logic [1:0]         b00, b10, b01, b11;
	logic signed [XQ_W:0] fsum;
	// stage 5
	logic               off_s5;
	logic signed [33:0] c_s5, c_c;
	logic signed [32:0] a_s5, b_s5, a_c, b_c;
	logic signed [FI_W-1:0] fxi_s5, fzi_s5;
	logic [FRAC_BITS-1:0]   fxf_s5, fzf_s5;
	// stage 6
	logic               off_s6;
	logic signed [33:0] c_s6;
	logic signed [56:0] pai_s6, pbi_s6;
	logic signed [57:0] paf_s6, pbf_s6;
	// stage 7
	logic               off_s7;
	logic signed [SUM_W-1:0] ip_s7, fp_s7;
	// stage 8
	logic signed [SUM_W-1:0] res_c;
	out_item_t          out_s8;

	assign en8 = !v_s8 || !out_stall;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s8;
	assign out_data = out_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_scale_q <= 32'd16777216;
			z_scale_q <= 32'd16777216;
			grid_cols_q <= 7'd64;
			grid_rows_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_X_SCALE:   x_scale_q <= cfg_data;
				CFG_Z_SCALE:   z_scale_q <= cfg_data;
				CFG_GRID_COLS: grid_cols_q <= cfg_data[6:0];
				CFG_GRID_ROWS: grid_rows_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_cols_q < 7'd2) nc = NCOL_W'(2);
		else if (grid_cols_q > 7'(GRID_W)) nc = NCOL_W'(GRID_W);
		else nc = NCOL_W'(grid_cols_q);
		if (grid_rows_q < 9'd2) nr = NROW_W'(2);
		else if (grid_rows_q > 9'(GRID_H)) nr = NROW_W'(GRID_H);
		else nr = NROW_W'(grid_rows_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			// drop writes once they reach the RAM
			if (en3) v_s3 <= v_s2 && (cmd_s2 == CMD_QUERY);
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// stage 1: scale products
	assign negz = -$signed({in_data.pos_z[31], in_data.pos_z});
	assign zprod_full = negz * $signed({1'b0, z_scale_q});

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1 <= in_data.cmd;
			col_s1 <= in_data.col;
			row_s1 <= in_data.row;
			elev_s1 <= in_data.elevation;
			xprod_s1 <= 64'(in_data.pos_x * $signed({1'b0, x_scale_q}));
			zprod_s1 <= zprod_full[63:0];
		end
	end

	// stage 2: cell origin and range check
	assign xq_c = xprod_s1[63:16];
	assign zq_c = zprod_s1[63:16];

	always_comb begin
		if (xq_c[XQ_W-1]) x0_c = '0;
		else if (xq_c[XQ_W-2:FRAC_BITS] > (XQ_W-1-FRAC_BITS)'(nc - NCOL_W'(2)))
			x0_c = COL_W'(nc - NCOL_W'(2));
		else x0_c = xq_c[FRAC_BITS+COL_W-1:FRAC_BITS];
		if (zq_c[XQ_W-1]) z0_c = '0;
		else if (zq_c[XQ_W-2:FRAC_BITS] > (XQ_W-1-FRAC_BITS)'(nr - NROW_W'(2)))
			z0_c = ROW_W'(nr - NROW_W'(2));
		else z0_c = zq_c[FRAC_BITS+ROW_W-1:FRAC_BITS];
		off_c = xq_c[XQ_W-1] || zq_c[XQ_W-1]
			|| (xq_c > $signed({(XQ_W-FRAC_BITS-NCOL_W)'(0), nc - NCOL_W'(1),
				FRAC_BITS'(0)}))
			|| (zq_c > $signed({(XQ_W-FRAC_BITS-NROW_W)'(0), nr - NROW_W'(1),
				FRAC_BITS'(0)}));
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			cmd_s2 <= cmd_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			elev_s2 <= elev_s1;
			xq_s2 <= xq_c;
			zq_s2 <= zq_c;
			x0_s2 <= x0_c;
			z0_s2 <= z0_c;
			off_s2 <= off_c;
		end
	end

	// stage 3: corner reads, one bank per column and row parity
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [COL_W-1:0] rc;
		logic [ROW_W-1:0] rr;
		logic             wsel;
		assign rc = (x0_s2[0] == 1'(k % 2)) ? x0_s2 : x0_s2 + COL_W'(1);
		assign rr = (z0_s2[0] == 1'(k / 2)) ? z0_s2 : z0_s2 + ROW_W'(1);
		assign wsel = en3 && v_s2 && (cmd_s2 == CMD_WRITE)
			&& (col_s2[0] == 1'(k % 2)) && (row_s2[0] == 1'(k / 2));
		hhl_ram #(.WIDTH(ELEV_W), .DEPTH(BANK_DEPTH)) u_ram (
			.clk  (clk),
			.we   (wsel),
			.waddr({row_s2[ROW_W-1:1], col_s2[COL_W-1:1]}),
			.wdata(elev_s2),
			.re   (en3),
			.raddr({rr[ROW_W-1:1], rc[COL_W-1:1]}),
			.rdata(rdata[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			off_s3 <= off_s2;
			xp_s3 <= x0_s2[0];
			zp_s3 <= z0_s2[0];
			fx_s3 <= xq_s2 - $signed({(XQ_W-FRAC_BITS-COL_W)'(0), x0_s2, FRAC_BITS'(0)});
			fz_s3 <= zq_s2 - $signed({(XQ_W-FRAC_BITS-ROW_W)'(0), z0_s2, FRAC_BITS'(0)});
		end
	end

	// stage 4: triangle choice
	assign b00 = {zp_s3, xp_s3};
	assign b10 = {zp_s3, !xp_s3};
	assign b01 = {!zp_s3, xp_s3};
	assign b11 = {!zp_s3, !xp_s3};
	assign fsum = fx_s3 + fz_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			off_s4 <= off_s3;
			odd_s4 <= xp_s3 ^ zp_s3;
			low_s4 <= (xp_s3 ^ zp_s3) ? (fsum < $signed((XQ_W+1)'(1) <<< FRAC_BITS))
				: (fz_s3 < fx_s3);
			fx_s4 <= fx_s3;
			fz_s4 <= fz_s3;
			h00_s4 <= rdata[b00];
			h10_s4 <= rdata[b10];
			h01_s4 <= rdata[b01];
			h11_s4 <= rdata[b11];
		end
	end

	// stage 5: plane coefficients
	always_comb begin
		if (!odd_s4) begin
			c_c = 34'(h00_s4);
			if (low_s4) begin
				a_c = 33'(h10_s4) - 33'(h00_s4);
				b_c = 33'(h11_s4) - 33'(h10_s4);
			end else begin
				a_c = 33'(h11_s4) - 33'(h01_s4);
				b_c = 33'(h01_s4) - 33'(h00_s4);
			end
		end else if (low_s4) begin
			c_c = 34'(h00_s4);
			a_c = 33'(h10_s4) - 33'(h00_s4);
			b_c = 33'(h01_s4) - 33'(h00_s4);
		end else begin
			c_c = 34'(h01_s4) + 34'(h10_s4) - 34'(h11_s4);
			a_c = 33'(h11_s4) - 33'(h01_s4);
			b_c = 33'(h11_s4) - 33'(h10_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			off_s5 <= off_s4;
			c_s5 <= c_c;
			a_s5 <= a_c;
			b_s5 <= b_c;
			fxi_s5 <= fx_s4[XQ_W-1:FRAC_BITS];
			fzi_s5 <= fz_s4[XQ_W-1:FRAC_BITS];
			fxf_s5 <= fx_s4[FRAC_BITS-1:0];
			fzf_s5 <= fz_s4[FRAC_BITS-1:0];
		end
	end

	// stage 6: products
	always_ff @(posedge clk) begin
		if (en6) begin
			off_s6 <= off_s5;
			c_s6 <= c_s5;
			pai_s6 <= a_s5 * fxi_s5;
			pbi_s6 <= b_s5 * fzi_s5;
			paf_s6 <= a_s5 * $signed({1'b0, fxf_s5});
			pbf_s6 <= b_s5 * $signed({1'b0, fzf_s5});
		end
	end

	// stage 7: integer and fraction sums, half-up rounding offset
	always_ff @(posedge clk) begin
		if (en7) begin
			off_s7 <= off_s6;
			ip_s7 <= SUM_W'(c_s6) + SUM_W'(pai_s6) + SUM_W'(pbi_s6);
			fp_s7 <= SUM_W'(paf_s6) + SUM_W'(pbf_s6)
				+ $signed(SUM_W'(1) <<< (FRAC_BITS - 1));
		end
	end

	// stage 8: combine and saturate
	assign res_c = ip_s7 + (fp_s7 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en8) begin
			out_s8.off_grid <= off_s7;
			if (res_c > $signed(SUM_W'(32'sh7FFFFFFF)))
				out_s8.height <= 32'sh7FFFFFFF;
			else if (res_c < -$signed(SUM_W'(1) <<< 31))
				out_s8.height <= 32'sh80000000;
			else
				out_s8.height <= res_c[31:0];
		end
	end

	`HHL_ASSERT(a_empty_accepts, clk, arst_n, !out_valid |-> !in_stall)
	`HHL_ASSERT(a_cell_in_grid, clk, arst_n, v_s2 && cmd_s2 |-> x0_s2 <= COL_W'(GRID_W - 2))
	`HHL_ASSERT(a_s1_holds, clk, arst_n, v_s1 && !en2 |=> v_s1 && $stable(xprod_s1))
	`HHL_NEVER(a_write_no_result, clk, arst_n, v_s3 && $past(en3) && $past(v_s2) && ($past(cmd_s2) == CMD_WRITE))
endmodule

### tb/hhl_height_checker.sv
// Checker for the height lookup block: snoops the register port and both
// channels, predicts every query result and compares it. Depends on hhl_pkg.
`timescale 1ns / 1ps
module hhl_height_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  hhl_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  hhl_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending
);
	import hhl_pkg::*;

	localparam longint ONE = 64'sd1 <<< FRAC_BITS;

	logic signed [31:0] elev_mem [GRID_W * GRID_H];
	logic [31:0] x_scale, z_scale;
	logic [6:0] grid_cols;
	logic [8:0] grid_rows;
	out_item_t heights_due[$];

	function automatic int axis_cell(longint q, int n);
		longint i;
		if (q < 0)
			return 0;
		i = q >>> FRAC_BITS;
		if (i > n - 2)
			i = n - 2;
		return int'(i);
	endfunction

	function automatic int fit_size(int n, int hi);
		if (n < 2)
			return 2;
		return (n > hi) ? hi : n;
	endfunction

	function automatic out_item_t interpolate_height(in_item_t it);
		out_item_t r;
		int nc, nr, x0, z0;
		longint xq, zq, fx, fz, h00, h10, h01, h11, c, a, b, ipart, fpart, res;
		nc = fit_size(grid_cols, GRID_W);
		nr = fit_size(grid_rows, GRID_H);
		xq = (longint'(it.pos_x) * longint'(x_scale)) >>> 16;
		zq = ((-longint'(it.pos_z)) * longint'(z_scale)) >>> 16;
		r.off_grid = xq < 0 || xq > (longint'(nc - 1) <<< FRAC_BITS) ||
			zq < 0 || zq > (longint'(nr - 1) <<< FRAC_BITS);
		x0 = axis_cell(xq, nc);
		z0 = axis_cell(zq, nr);
		fx = xq - longint'(x0) * ONE;
		fz = zq - longint'(z0) * ONE;
		h00 = elev_mem[z0 * GRID_W + x0];
		h10 = elev_mem[z0 * GRID_W + x0 + 1];
		h01 = elev_mem[(z0 + 1) * GRID_W + x0];
		h11 = elev_mem[(z0 + 1) * GRID_W + x0 + 1];
		if (((x0 + z0) & 1) == 0) begin
			c = h00;
			if (fz < fx) begin
				a = h10 - h00;
				b = h11 - h10;
			end else begin
				a = h11 - h01;
				b = h01 - h00;
			end
		end else if (fx + fz < ONE) begin
			c = h00;
			a = h10 - h00;
			b = h01 - h00;
		end else begin
			c = h01 + h10 - h11;
			a = h11 - h01;
			b = h11 - h10;
		end
		ipart = c + a * (fx >>> FRAC_BITS) + b * (fz >>> FRAC_BITS);
		fpart = a * (fx & (ONE - 1)) + b * (fz & (ONE - 1));
		res = ipart + ((fpart + (ONE >>> 1)) >>> FRAC_BITS);
		if (res > 64'sd2147483647)
			res = 64'sd2147483647;
		if (res < -64'sd2147483648)
			res = -64'sd2147483648;
		r.height = res[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			x_scale <= 32'h0100_0000;
			z_scale <= 32'h0100_0000;
			grid_cols <= 7'd64;
			grid_rows <= 9'd256;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_X_SCALE: x_scale <= cfg_data;
					CFG_Z_SCALE: z_scale <= cfg_data;
					CFG_GRID_COLS: grid_cols <= cfg_data[6:0];
					CFG_GRID_ROWS: grid_rows <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (heights_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual height %h off_grid %b",
						$time, out_data.height, out_data.off_grid);
				end else begin
					want = heights_due.pop_front();
					if (out_data.height !== want.height) begin
						fail_count++;
						$display("%0t: height: expected %h, actual %h", $time,
							want.height, out_data.height);
					end
					if (out_data.off_grid !== want.off_grid) begin
						fail_count++;
						$display("%0t: off_grid: expected %b, actual %b", $time,
							want.off_grid, out_data.off_grid);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.cmd == CMD_WRITE)
					elev_mem[in_data.row * GRID_W + in_data.col] = in_data.elevation;
				else
					heights_due.push_back(interpolate_height(in_data));
			end
			pending = heights_due.size();
		end
	end
endmodule

### tb/tb_heightfield_height_lookup_top.sv
// Testbench top for the height lookup block: clock, reset, register setup,
// directed and random transactions, verdict. Depends on hhl_pkg, hhl_height_checker.
`timescale 1ns / 1ps
module tb_heightfield_height_lookup_top;
	import hhl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int fail_count, pending;
	int cycles = 0;
	bit burst = 0;
	bit hold_long = 0;
	bit written [GRID_W * GRID_H];
	logic [31:0] cur_xs, cur_zs;
	int cur_nc, cur_nr;

	heightfield_height_lookup_top dut (.*);

	hhl_height_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 7);
			if (hold_long) begin
				n = 120;
				hold_long = 0;
			end
			@(negedge clk);
			out_stall = 1'b1;
			repeat (n) @(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic int axis_cell(longint p, logic [31:0] s, int n);
		longint q;
		q = (p * longint'(s)) >>> 16;
		if (q < 0)
			return 0;
		q = q >>> FRAC_BITS;
		return (q > n - 2) ? n - 2 : int'(q);
	endfunction

	function automatic bit corners_written(logic signed [31:0] px, logic signed [31:0] pz);
		int x0, z0;
		x0 = axis_cell(longint'(px), cur_xs, cur_nc);
		z0 = axis_cell(-longint'(pz), cur_zs, cur_nr);
		return written[z0 * GRID_W + x0] && written[z0 * GRID_W + x0 + 1] &&
			written[(z0 + 1) * GRID_W + x0] && written[(z0 + 1) * GRID_W + x0 + 1];
	endfunction

	task automatic send(in_item_t it);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (in_stall);
		if (it.cmd == CMD_WRITE)
			written[it.row * GRID_W + it.col] = 1;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic put_elev(int c, int r, logic [31:0] v);
		in_item_t it;
		it = '0;
		it.cmd = CMD_WRITE;
		it.col = 6'(c);
		it.row = 8'(r);
		it.elevation = v;
		send(it);
	endtask

	task automatic ask(logic [31:0] px, logic [31:0] pz);
		in_item_t it;
		it = '0;
		it.cmd = CMD_QUERY;
		it.pos_x = px;
		it.pos_z = pz;
		it.col = 6'($urandom);
		it.row = 8'($urandom);
		it.elevation = $urandom;
		send(it);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_grid(logic [31:0] xs, logic [31:0] zs, logic [6:0] nc, logic [8:0] nr);
		write_reg(CFG_X_SCALE, xs);
		write_reg(CFG_Z_SCALE, zs);
		write_reg(CFG_GRID_COLS, {25'd0, nc});
		write_reg(CFG_GRID_ROWS, {23'd0, nr});
		cur_xs = xs;
		cur_zs = zs;
		cur_nc = (nc < 2) ? 2 : (nc > GRID_W) ? GRID_W : nc;
		cur_nr = (nr < 2) ? 2 : (nr > GRID_H) ? GRID_H : nr;
	endtask

	function automatic int pick_index(int n, int lim);
		int k;
		k = $urandom_range(0, 4);
		case ($urandom_range(0, 4))
			0, 1: return k;
			2, 3: return (n - 1 - k < 0) ? 0 : n - 1 - k;
			default: return $urandom_range(0, lim - 1);
		endcase
	endfunction

	function automatic logic [31:0] grid_to_pos(int n, logic [31:0] s);
		longint g, p;
		case ($urandom_range(0, 5))
			0: g = -longint'($urandom_range(1, 3));
			1: g = n - 1 + $urandom_range(0, 2);
			2: g = n - 1;
			default: g = $urandom_range(0, (n > 4) ? 3 : n - 1);
		endcase
		g = (g <<< FRAC_BITS) + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 24'hFFFFFF));
		if (s == 0)
			return $urandom;
		p = (g <<< 16) / longint'(s);
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		return p[31:0];
	endfunction

	task automatic random_items(int count);
		logic [31:0] px, pz;
		bit ok;
		repeat (count) begin
			if ($urandom_range(0, 99) < 35) begin
				put_elev(pick_index(cur_nc, GRID_W), pick_index(cur_nr, GRID_H),
					$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000);
			end else begin
				ok = 0;
				for (int t = 0; t < 8 && !ok; t++) begin
					if ($urandom_range(0, 4) == 0) begin
						px = $urandom;
						pz = $urandom;
					end else begin
						px = grid_to_pos(cur_nc, cur_xs);
						pz = -grid_to_pos(cur_nr, cur_zs);
					end
					ok = corners_written(px, pz);
				end
				if (!ok) begin
					px = 0;
					pz = 0;
				end
				ask(px, pz);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_grid(32'h0100_0000, 32'h0100_0000, 7'd4, 9'd4);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				put_elev(c, r, (c == 0 && r == 0) ? 32'h7FFF_FFFF :
					(c == 1 && r == 0) ? 32'h8000_0000 : $urandom_range(0, 32'h3_FFFF));
		ask(32'h0000_0000, 32'h0000_0000);
		ask(32'h0001_4000, 32'hFFFF_8000);
		ask(32'h0001_C000, 32'hFFFF_8000);
		ask(32'h0000_4000, 32'hFFFF_4000);
		ask(32'h0000_C000, 32'hFFFF_C000);
		ask(32'h0003_0000, 32'hFFFD_0000);
		ask(32'hFFFB_0000, 32'h0005_0000);
		ask(32'h0064_0000, 32'hFF9C_0000);
		ask(32'h7FFF_FFFF, 32'h8000_0000);
		ask(32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();

		set_grid(32'hFFFF_FFFF, 32'h0000_0000, 7'd2, 9'd2);
		random_items(180);
		wait_drained();

		set_grid(32'h0100_0000, 32'h0100_0000, 7'd64, 9'd256);
		burst = 1;
		hold_long = 1;
		random_items(120);
		burst = 0;
		random_items(120);
		wait_drained();

		set_grid($urandom_range(32'h0040_0000, 32'h0400_0000),
			$urandom_range(32'h0040_0000, 32'h0400_0000),
			7'($urandom_range(2, 64)), 9'($urandom_range(2, 256)));
		random_items(220);
		wait_drained();

		set_grid(32'h0000_0000, 32'hFFFF_FFFF, 7'd127, 9'd0);
		random_items(150);
		wait_drained();

		set_grid($urandom_range(32'h0080_0000, 32'h0200_0000), 32'h0100_0000, 7'd1, 9'd511);
		random_items(150);
		wait_drained();

		set_grid($urandom, $urandom, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)));
		random_items(170);
		wait_drained();

		set_grid(32'h0100_0000, 32'h0080_0000, 7'd8, 9'd6);
		burst = 1;
		random_items(100);
		burst = 0;
		wait_drained();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

### sim.f
+incdir+rtl
rtl/hhl_pkg.sv
rtl/hhl_ram.sv
rtl/heightfield_height_lookup_top.sv
tb/hhl_height_checker.sv
tb/tb_heightfield_height_lookup_top.sv
